/* design/vqe_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vqe_pkg
// Shared types and constants of the vector quantizer encoder.
// ----------------------------------------------------------------------------
package vqe_pkg;

  localparam int ELEM_BITS = 16;
  localparam int VEC_DIM   = 4;
  localparam int IDX_W     = 6;
  localparam int OP_W      = 2;
  localparam int CFG_W     = 7;
  localparam int DIM_W     = 3;
  localparam int LANE_W    = DIM_W + 1;
  localparam int SQ_W      = 2 * ELEM_BITS;
  localparam int DIST_W    = 2 * ELEM_BITS + $clog2(VEC_DIM);

  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic CFG_IDX_COUNT = 1'b0;
  localparam logic CFG_IDX_DIMS  = 1'b1;

  localparam logic [CFG_W-1:0] COUNT_RESET = 7'd64;
  localparam logic [DIM_W-1:0] DIMS_RESET  = 3'd4;

  typedef logic [ELEM_BITS-1:0] elem_t;
  typedef elem_t [VEC_DIM-1:0]  vec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } ctl_state_t;

  typedef struct packed {
    logic latch;
    logic mem_wr;
    logic rd_idx;
    logic scan_rd;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic pipe_busy;
  } ctl_sts_t;

endpackage
`default_nettype wire

/* design/vector_quantizer_encoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vector_quantizer_encoder
// Full-search vector quantizer with a writable codebook.
// ----------------------------------------------------------------------------
// One request at a time, one result per request. A write goes from accept
// straight to the done state, a read passes one read state, and an encode
// scans the codewords in use: the scan reads one codeword per cycle through
// the single read port of the codebook memory, then drains a three-stage
// distance pipeline (squares, sum, compare). A new request is taken while the
// previous result still waits in the output register. Codebook entries come
// up undefined after reset; read or search only entries already written.
// ----------------------------------------------------------------------------
module vector_quantizer_encoder
  import vqe_pkg::*;
#(
  parameter int MAX_CODEWORDS = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [OP_W-1:0]             in_opcode,
  input  wire logic [IDX_W-1:0]            in_entry_index,
  input  wire logic signed [ELEM_BITS-1:0] in_elem_0,
  input  wire logic signed [ELEM_BITS-1:0] in_elem_1,
  input  wire logic signed [ELEM_BITS-1:0] in_elem_2,
  input  wire logic signed [ELEM_BITS-1:0] in_elem_3,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_status,
  output logic [IDX_W-1:0]                 out_best_index,
  output logic [DIST_W-1:0]                out_distortion,
  output logic signed [ELEM_BITS-1:0]      out_elem_0,
  output logic signed [ELEM_BITS-1:0]      out_elem_1,
  output logic signed [ELEM_BITS-1:0]      out_elem_2,
  output logic signed [ELEM_BITS-1:0]      out_elem_3,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [CFG_W-1:0]            cfg_wdata
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;
  vec_t     in_vec;
  vec_t     out_vec;

  assign in_vec[0] = in_elem_0;
  assign in_vec[1] = in_elem_1;
  assign in_vec[2] = in_elem_2;
  assign in_vec[3] = in_elem_3;

  assign out_elem_0 = out_vec[0];
  assign out_elem_1 = out_vec[1];
  assign out_elem_2 = out_vec[2];
  assign out_elem_3 = out_vec[3];

  vqe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  vqe_dpath #(
    .MAX_CODEWORDS (MAX_CODEWORDS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_opcode      (in_opcode),
    .in_entry_index (in_entry_index),
    .in_vec         (in_vec),
    .cmd            (cmd),
    .sts            (sts),
    .out_status     (out_status),
    .out_best_index (out_best_index),
    .out_distortion (out_distortion),
    .out_vec        (out_vec)
  );

endmodule
`default_nettype wire

/* design/vqe_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vqe_ctrl
// Sequencer: accepts a request, steps the codebook scan, hands off the result.
// ----------------------------------------------------------------------------
module vqe_ctrl
  import vqe_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [OP_W-1:0] in_opcode,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output ctl_cmd_t             cmd,
  input  wire ctl_sts_t        sts
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          unique case (in_opcode)
            OP_WRITE: begin
              cmd.mem_wr = 1'b1;
              state_nxt  = ST_DONE;
            end
            OP_ENCODE: state_nxt = ST_SCAN;
            OP_READ:   state_nxt = ST_READ;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_READ: begin
        cmd.rd_idx = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // output register free, or emptied this cycle
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cmd.load_out)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

/* design/vqe_dpath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vqe_dpath
// Config registers, codebook memory, distance pipeline and result register.
// ----------------------------------------------------------------------------
module vqe_dpath
  import vqe_pkg::*;
#(
  parameter int MAX_CODEWORDS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  input  wire logic [OP_W-1:0]  in_opcode,
  input  wire logic [IDX_W-1:0] in_entry_index,
  input  wire vec_t             in_vec,
  input  wire ctl_cmd_t         cmd,
  output ctl_sts_t              sts,
  output logic                  out_status,
  output logic [IDX_W-1:0]      out_best_index,
  output logic [DIST_W-1:0]     out_distortion,
  output vec_t                  out_vec
);

  localparam int AW    = $clog2(MAX_CODEWORDS);
  localparam int CNT_W = ($clog2(MAX_CODEWORDS + 1) > CFG_W) ?
                         $clog2(MAX_CODEWORDS + 1) : CFG_W;

  // configuration
  logic [CFG_W-1:0] count_r;
  logic [DIM_W-1:0] dims_r;
  logic [CNT_W-1:0] eff_count;
  logic [DIM_W-1:0] eff_dims;
  logic [CNT_W-1:0] count_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
      dims_r  <= DIMS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_COUNT: count_r <= cfg_wdata;
        CFG_IDX_DIMS:  dims_r  <= cfg_wdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    count_ext = CNT_W'(count_r);
    if (count_ext == '0)
      eff_count = CNT_W'(1);
    else if (count_ext > CNT_W'(MAX_CODEWORDS))
      eff_count = CNT_W'(MAX_CODEWORDS);
    else
      eff_count = count_ext;

    if (dims_r == '0)
      eff_dims = DIM_W'(1);
    else if (LANE_W'(dims_r) > LANE_W'(VEC_DIM))
      eff_dims = DIM_W'(VEC_DIM);
    else
      eff_dims = dims_r;
  end

  // item latch
  logic [OP_W-1:0] op_r;
  logic [AW-1:0]   idx_r;
  logic            in_range_r;
  vec_t            x_r;
  logic            in_range;

  assign in_range = CNT_W'(in_entry_index) < eff_count;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r       <= in_opcode;
      idx_r      <= AW'(in_entry_index);
      in_range_r <= in_range;
      x_r        <= in_vec;
    end
  end

  // scan counter
  logic [AW-1:0] scan_cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.latch)        scan_cnt_r <= '0;
    else if (cmd.scan_rd) scan_cnt_r <= scan_cnt_r + AW'(1);
  end

  assign sts.scan_last = (scan_cnt_r == AW'(eff_count - CNT_W'(1)));

  // codebook memory, per-element write enable
  vec_t          mem [MAX_CODEWORDS];
  vec_t          rd_r;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  assign rd_en   = cmd.rd_idx | cmd.scan_rd;
  assign rd_addr = cmd.scan_rd ? scan_cnt_r : idx_r;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && in_range) begin
      for (int d = 0; d < VEC_DIM; d++) begin
        if (LANE_W'(d) < LANE_W'(eff_dims))
          mem[AW'(in_entry_index)][d] <= in_vec[d];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_r <= mem[rd_addr];
  end

  // distance pipeline: read data -> squares -> sum -> compare
  logic                  v1_r, v2_r, v3_r;
  logic [AW-1:0]         tag1_r, tag2_r, tag3_r;
  logic [VEC_DIM-1:0][SQ_W-1:0] sq_r, sq_nxt;
  logic [DIST_W-1:0]     sum_r, sum_nxt;
  logic [AW-1:0]         best_idx_r;
  logic [DIST_W-1:0]     best_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.scan_rd;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign sts.pipe_busy = v1_r | v2_r | v3_r;

  always_comb begin
    logic [ELEM_BITS:0]   diff;
    logic [ELEM_BITS:0]   mag;
    logic [ELEM_BITS-1:0] absd;
    diff = '0;
    mag  = '0;
    absd = '0;
    for (int d = 0; d < VEC_DIM; d++) begin
      diff = {x_r[d][ELEM_BITS-1], x_r[d]} - {rd_r[d][ELEM_BITS-1], rd_r[d]};
      mag  = diff[ELEM_BITS] ? (~diff + (ELEM_BITS+1)'(1)) : diff;
      absd = mag[ELEM_BITS-1:0];
      if (LANE_W'(d) < LANE_W'(eff_dims))
        sq_nxt[d] = SQ_W'(absd * absd);
      else
        sq_nxt[d] = '0;
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int d = 0; d < VEC_DIM; d++)
      sum_nxt = sum_nxt + DIST_W'(sq_r[d]);
  end

  always_ff @(posedge clk) begin
    tag1_r <= scan_cnt_r;
    tag2_r <= tag1_r;
    tag3_r <= tag2_r;
    sq_r   <= sq_nxt;
    sum_r  <= sum_nxt;
    // first codeword seeds the search; strict less keeps lowest index on ties
    if (v3_r && ((tag3_r == '0) || (sum_r < best_sum_r))) begin
      best_idx_r <= tag3_r;
      best_sum_r <= sum_r;
    end
  end

  // result register
  logic              status_r, status_nxt;
  logic [IDX_W-1:0]  best_out_r, best_out_nxt;
  logic [DIST_W-1:0] dist_out_r, dist_out_nxt;
  vec_t              elem_out_r, elem_out_nxt;

  always_comb begin
    status_nxt   = 1'b0;
    best_out_nxt = '0;
    dist_out_nxt = '0;
    elem_out_nxt = '0;
    case (op_r)
      OP_WRITE: status_nxt = !in_range_r;
      OP_ENCODE: begin
        best_out_nxt = IDX_W'(best_idx_r);
        dist_out_nxt = best_sum_r;
      end
      OP_READ: begin
        status_nxt = !in_range_r;
        if (in_range_r) begin
          for (int d = 0; d < VEC_DIM; d++) begin
            if (LANE_W'(d) < LANE_W'(eff_dims)) elem_out_nxt[d] = rd_r[d];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status_r   <= status_nxt;
      best_out_r <= best_out_nxt;
      dist_out_r <= dist_out_nxt;
      elem_out_r <= elem_out_nxt;
    end
  end

  assign out_status     = status_r;
  assign out_best_index = best_out_r;
  assign out_distortion = dist_out_r;
  assign out_vec        = elem_out_r;

endmodule
`default_nettype wire

/* tb/sv/vqe_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vqe_result_checker
// Predicts and checks every result of the vector quantizer encoder.
// ----------------------------------------------------------------------------
// Snoops the configuration port and both handshake channels. Each accepted
// request is run through a private copy of the codebook and registers, and the
// predicted result is queued. Each accepted result is compared field by field
// with the oldest prediction.
// ----------------------------------------------------------------------------
module vqe_result_checker
  import vqe_pkg::*;
#(
  parameter int MAX_CODEWORDS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [OP_W-1:0]      in_opcode,
  input  logic [IDX_W-1:0]     in_entry_index,
  input  logic [ELEM_BITS-1:0] in_elem_0,
  input  logic [ELEM_BITS-1:0] in_elem_1,
  input  logic [ELEM_BITS-1:0] in_elem_2,
  input  logic [ELEM_BITS-1:0] in_elem_3,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 out_status,
  input  logic [IDX_W-1:0]     out_best_index,
  input  logic [DIST_W-1:0]    out_distortion,
  input  logic [ELEM_BITS-1:0] out_elem_0,
  input  logic [ELEM_BITS-1:0] out_elem_1,
  input  logic [ELEM_BITS-1:0] out_elem_2,
  input  logic [ELEM_BITS-1:0] out_elem_3,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct packed {
    logic               status;
    logic [IDX_W-1:0]   best_index;
    logic [DIST_W-1:0]  distortion;
    vec_t               elems;
  } vq_result_t;

  vec_t             codebook [MAX_CODEWORDS];
  logic [CFG_W-1:0] count_reg;
  logic [DIM_W-1:0] dims_reg;
  vq_result_t       result_q [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Out-of-range register values clamp to the legal span.
  function automatic int active_count();
    if (count_reg == 0) return 1;
    if (count_reg > MAX_CODEWORDS) return MAX_CODEWORDS;
    return int'(count_reg);
  endfunction

  function automatic int active_dims();
    if (dims_reg == 0) return 1;
    if (dims_reg > VEC_DIM) return VEC_DIM;
    return int'(dims_reg);
  endfunction

  function automatic logic [DIST_W-1:0] sq_distance(input vec_t a, input vec_t b,
                                                     input int dims);
    longint acc;
    longint diff;
    acc = 0;
    for (int d = 0; d < dims; d++) begin
      diff = longint'($signed(a[d])) - longint'($signed(b[d]));
      acc  = acc + diff * diff;
    end
    return acc[DIST_W-1:0];
  endfunction

  task automatic predict_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                                 input vec_t x);
    vq_result_t        r;
    int                cnt;
    int                dims;
    logic [DIST_W-1:0] min_sum;
    logic [DIST_W-1:0] cand_sum;
    r    = '0;
    cnt  = active_count();
    dims = active_dims();
    case (op)
      OP_WRITE, OP_READ: begin
        if (int'(idx) >= cnt) begin
          r.status = 1'b1;
        end else if (op == OP_WRITE) begin
          // only the elements in use are overwritten
          for (int d = 0; d < dims; d++) codebook[idx][d] = x[d];
        end else begin
          for (int d = 0; d < dims; d++) r.elems[d] = codebook[idx][d];
        end
      end
      OP_ENCODE: begin
        min_sum = sq_distance(x, codebook[0], dims);
        for (int k = 1; k < cnt; k++) begin
          cand_sum = sq_distance(x, codebook[k], dims);
          // strict compare keeps the lowest index on ties
          if (cand_sum < min_sum) begin
            min_sum      = cand_sum;
            r.best_index = IDX_W'(k);
          end
        end
        r.distortion = min_sum;
      end
      default: ;
    endcase
    result_q.push_back(r);
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] seen);
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
    mismatches++;
  endtask

  always @(posedge clk) begin
    vq_result_t want;
    vq_result_t seen;
    if (!rst_n) begin
      for (int k = 0; k < MAX_CODEWORDS; k++) codebook[k] = '0;
      count_reg = COUNT_RESET;
      dims_reg  = DIMS_RESET;
      result_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_COUNT) count_reg = cfg_wdata;
        else                            dims_reg  = cfg_wdata[DIM_W-1:0];
      end
      if (in_valid && in_ready)
        predict_request(in_opcode, in_entry_index,
                        {in_elem_3, in_elem_2, in_elem_1, in_elem_0});
      if (out_valid && out_ready) begin
        seen = {out_status, out_best_index, out_distortion,
                out_elem_3, out_elem_2, out_elem_1, out_elem_0};
        if (result_q.size() == 0) begin
          $display("%0t ns: result with no request outstanding, expected none, actual %0h",
                   $time, seen);
          mismatches++;
        end else begin
          want = result_q.pop_front();
          if (seen.status !== want.status)
            report_mismatch("status", 64'(want.status), 64'(seen.status));
          if (seen.best_index !== want.best_index)
            report_mismatch("best_index", 64'(want.best_index), 64'(seen.best_index));
          if (seen.distortion !== want.distortion)
            report_mismatch("distortion", 64'(want.distortion), 64'(seen.distortion));
          for (int d = 0; d < VEC_DIM; d++) begin
            if (seen.elems[d] !== want.elems[d])
              report_mismatch($sformatf("out_elem_%0d", d), 64'(want.elems[d]),
                              64'(seen.elems[d]));
          end
        end
      end
    end
    outstanding = result_q.size();
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the vector quantizer encoder.
// ----------------------------------------------------------------------------
// A directed opening loads a small codebook with corner vectors and hits
// ties, out-of-range indexes, the unused opcode and the largest distortion.
// Random phases then sweep the registers, including clamped values, and mix
// codebook loads, reads and searches. Searches and reads only touch entries
// that were loaded. Both channels stall in random bursts, except at the end.
// ----------------------------------------------------------------------------
module tb_top;
  import vqe_pkg::*;

  localparam logic [OP_W-1:0] OP_NOP      = 2'd3;
  localparam int              MAX_ENTRIES = 64;
  localparam int              RECENT      = 8;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      in_opcode      = '0;
  logic [IDX_W-1:0]     in_entry_index = '0;
  logic [ELEM_BITS-1:0] in_elem_0      = '0;
  logic [ELEM_BITS-1:0] in_elem_1      = '0;
  logic [ELEM_BITS-1:0] in_elem_2      = '0;
  logic [ELEM_BITS-1:0] in_elem_3      = '0;
  logic                 out_valid;
  logic                 out_ready      = 1'b0;
  logic                 out_status;
  logic [IDX_W-1:0]     out_best_index;
  logic [DIST_W-1:0]    out_distortion;
  logic [ELEM_BITS-1:0] out_elem_0;
  logic [ELEM_BITS-1:0] out_elem_1;
  logic [ELEM_BITS-1:0] out_elem_2;
  logic [ELEM_BITS-1:0] out_elem_3;
  logic                 cfg_we         = 1'b0;
  logic                 cfg_index      = CFG_IDX_COUNT;
  logic [CFG_W-1:0]     cfg_wdata      = '0;
  int                   mismatches;
  int                   outstanding;

  bit                   idling = 1'b1;
  logic [CFG_W-1:0]     cur_count = COUNT_RESET;
  logic [DIM_W-1:0]     cur_dims  = DIMS_RESET;
  bit [VEC_DIM-1:0]     loaded [MAX_ENTRIES];
  vec_t                 recent [RECENT];
  int                   recent_wr = 0;

  vector_quantizer_encoder #(.MAX_CODEWORDS(MAX_ENTRIES)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_entry_index(in_entry_index),
    .in_elem_0(in_elem_0), .in_elem_1(in_elem_1),
    .in_elem_2(in_elem_2), .in_elem_3(in_elem_3),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_best_index(out_best_index),
    .out_distortion(out_distortion),
    .out_elem_0(out_elem_0), .out_elem_1(out_elem_1),
    .out_elem_2(out_elem_2), .out_elem_3(out_elem_3),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  vqe_result_checker #(.MAX_CODEWORDS(MAX_ENTRIES)) result_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_entry_index(in_entry_index),
    .in_elem_0(in_elem_0), .in_elem_1(in_elem_1),
    .in_elem_2(in_elem_2), .in_elem_3(in_elem_3),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_best_index(out_best_index),
    .out_distortion(out_distortion),
    .out_elem_0(out_elem_0), .out_elem_1(out_elem_1),
    .out_elem_2(out_elem_2), .out_elem_3(out_elem_3),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("[vector_quantizer_encoder] ERROR");
    $finish;
  end

  // result side back-pressure
  initial begin
    forever begin
      @(negedge clk);
      if (idling && rst_n && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  function automatic int use_count();
    if (cur_count == 0) return 1;
    if (cur_count > MAX_ENTRIES) return MAX_ENTRIES;
    return int'(cur_count);
  endfunction

  function automatic int use_dims();
    if (cur_dims == 0) return 1;
    if (cur_dims > VEC_DIM) return VEC_DIM;
    return int'(cur_dims);
  endfunction

  function automatic bit entry_loaded(input int idx);
    for (int d = 0; d < use_dims(); d++)
      if (!loaded[idx][d]) return 1'b0;
    return 1'b1;
  endfunction

  // lowest entry in use that a search could not yet touch safely, or -1
  function automatic int first_unloaded();
    for (int k = 0; k < use_count(); k++)
      if (!entry_loaded(k)) return k;
    return -1;
  endfunction

  function automatic elem_t corner_elem();
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Mostly reuse of recent vectors, exact or nudged, so that searches see
  // duplicate codewords and near ties.
  function automatic vec_t pick_vec();
    vec_t v;
    int   base;
    int   mode;
    base = $urandom_range(0, RECENT - 1);
    mode = $urandom_range(0, 9);
    for (int d = 0; d < VEC_DIM; d++) begin
      if (mode < 4)
        v[d] = ($urandom_range(0, 4) == 0) ? corner_elem() : elem_t'($urandom);
      else if (mode < 7)
        v[d] = recent[base][d];
      else
        v[d] = recent[base][d] + elem_t'($urandom_range(0, 64)) - elem_t'(32);
    end
    return v;
  endfunction

  // Entered and left just after a falling edge.
  task automatic send_request(input logic [OP_W-1:0] op, input int idx, input vec_t v);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_entry_index <= IDX_W'(idx);
    in_elem_0      <= v[0];
    in_elem_1      <= v[1];
    in_elem_2      <= v[2];
    in_elem_3      <= v[3];
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (op == OP_WRITE && idx < use_count())
      for (int d = 0; d < use_dims(); d++) loaded[idx][d] = 1'b1;
    recent[recent_wr] = v;
    recent_wr = (recent_wr + 1) % RECENT;
  endtask

  task automatic set_config(input logic [CFG_W-1:0] count, input logic [DIM_W-1:0] dims);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_COUNT;
    cfg_wdata <= count;
    @(negedge clk);
    cfg_index <= CFG_IDX_DIMS;
    cfg_wdata <= {4'($urandom_range(0, 15)), dims};
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_count = count;
    cur_dims  = dims;
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] count, input logic [DIM_W-1:0] dims,
                           input int n_items, input bit with_idling);
    int made;
    int searches;
    int idx;
    int roll;
    int gap;
    made     = 0;
    searches = 0;
    set_config(count, dims);
    idling = with_idling;
    while (made < n_items || searches < 6) begin
      idx  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAX_ENTRIES - 1)
                                         : $urandom_range(0, use_count() - 1);
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        send_request(OP_NOP, $urandom_range(0, MAX_ENTRIES - 1), pick_vec());
        made--;
      end else if (roll < 30) begin
        send_request(OP_WRITE, idx, pick_vec());
      end else if (roll < 55) begin
        if (idx >= use_count() || entry_loaded(idx)) send_request(OP_READ, idx, pick_vec());
        else                                          send_request(OP_WRITE, idx, pick_vec());
      end else begin
        // a search waits until every entry in use is loaded; fill first
        gap = first_unloaded();
        if (gap < 0) begin
          send_request(OP_ENCODE, $urandom_range(0, MAX_ENTRIES - 1), pick_vec());
          searches++;
        end else begin
          send_request(OP_WRITE, gap, pick_vec());
        end
      end
      made++;
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_config(7'd4, 3'd4);
    send_request(OP_WRITE, 0, {4{16'h8000}});
    send_request(OP_WRITE, 1, {4{16'h7FFF}});
    send_request(OP_WRITE, 2, '0);
    send_request(OP_WRITE, 3, '0);
    send_request(OP_ENCODE, 0, {4{16'h7FFF}});
    send_request(OP_ENCODE, 63, {4{16'h8000}});
    send_request(OP_ENCODE, 0, '0);
    send_request(OP_ENCODE, 0, {16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001});
    send_request(OP_WRITE, 1, {16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF});
    for (int k = 0; k < 4; k++) send_request(OP_READ, k, '0);
    send_request(OP_READ, 4, {4{16'hFFFF}});
    send_request(OP_READ, 63, '0);
    send_request(OP_WRITE, 4, {4{16'h5555}});
    send_request(OP_WRITE, 63, {4{16'hAAAA}});
    send_request(OP_NOP, 63, {4{16'hAAAA}});
    send_request(OP_NOP, 0, {4{16'h5555}});
    send_request(OP_WRITE, 0, {4{16'h7FFF}});
    // single codeword at the far corner: largest distortion
    set_config(7'd1, 3'd4);
    send_request(OP_ENCODE, 0, {4{16'h8000}});
    send_request(OP_READ, 1, '0);

    run_phase(7'd1, 3'd1, 45, 1'b1);
    run_phase(7'd0, 3'd2, 45, 1'b1);
    run_phase(7'd64, 3'd4, 60, 1'b1);
    run_phase(7'd127, 3'd3, 50, $urandom_range(0, 2) != 0);
    run_phase(7'd16, 3'd0, 45, 1'b1);
    run_phase(7'd8, 3'd7, 45, 1'b1);
    run_phase(7'd33, 3'd2, 45, 1'b1);
    run_phase(7'($urandom_range(2, 63)), 3'($urandom_range(1, 4)), 40, 1'b1);
    run_phase(7'd64, 3'd4, 60, 1'b0);

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[vector_quantizer_encoder] OK");
    end else begin
      $display("[vector_quantizer_encoder] ERROR");
    end
    $finish;
  end

endmodule
